@@ design/srse_pkg.sv @@
// Shared constants and types for the scanline run segment extractor.
// No dependencies; compiled first.
package srse_pkg;

  localparam int BYTE_W  = 8;
  localparam int SEG_W   = 9;
  localparam int GLYPH_W = 9;

  localparam int DEF_MAX_SEGMENTS = 20;
  localparam int DEF_MAX_WIDTH    = 256;

  localparam logic [GLYPH_W-1:0] GLYPH_WIDTH_RESET = 9'd64;

  // Segment store write strobes.
  typedef struct packed {
    logic start_we;
    logic end_we;
  } seg_wr_t;

endpackage

@@ design/srse_pix_if.sv @@
// Pixel byte channel: valid/ready handshake carrying eight packed pixels.
// Depends on srse_pkg.
interface srse_pix_if;
  import srse_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

@@ design/srse_seg_if.sv @@
// Segment channel: valid/ready handshake carrying one row segment.
// Depends on srse_pkg.
interface srse_seg_if;
  import srse_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] seg_start;
  logic [SEG_W-1:0] seg_end;
  logic             seg_final;
  logic             run_overflow;

  modport source (output valid, output seg_start, output seg_end, output seg_final,
                  output run_overflow, input ready);
  modport sink   (input valid, input seg_start, input seg_end, input seg_final,
                  input run_overflow, output ready);
endinterface

@@ design/srse_seg_store.sv @@
// Segment start/end memories: one write port, one registered read port.
// Depends on srse_pkg.
module srse_seg_store #(
  parameter int DEPTH = srse_pkg::DEF_MAX_SEGMENTS,
  parameter int AW    = 5
) (
  input  logic                       clk,
  input  srse_pkg::seg_wr_t          wr,
  input  logic [AW-1:0]              wr_addr,
  input  logic [srse_pkg::SEG_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [srse_pkg::SEG_W-1:0] rd_start,
  output logic [srse_pkg::SEG_W-1:0] rd_end
);
  import srse_pkg::*;

  logic [SEG_W-1:0] start_mem [DEPTH];
  logic [SEG_W-1:0] end_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.start_we) begin
      start_mem[wr_addr] <= wr_data;
    end
    if (wr.end_we) begin
      end_mem[wr_addr] <= wr_data;
    end
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
  end

endmodule

@@ design/scanline_run_segment_extractor.sv @@
// Scanline run segment extractor: top level with scan sequencer and output register.
// Depends on srse_pkg, srse_pix_if, srse_seg_if and srse_seg_store.
//
// Each pixel byte is scanned one pixel per cycle. Between its pixel
// transaction and the next one, a byte passes through its acceptance, the scan
// of its eight pixels and one row-end check; at the row end, padding pixels
// stop the scan early. The single write port of the segment store takes at
// most one run edge per cycle. The byte that reaches the glyph width ends the
// row and starts the readout: MAX_SEGMENTS segments, each a store read and
// then an output register load, stalled by back-pressure on the segment
// channel. No new byte is taken until the readout is done. The user must write
// glyph_width through glyph_width_we/glyph_width_data only while the block is
// idle; the block itself does not enforce this. Values above MAX_WIDTH
// saturate to MAX_WIDTH. The store needs no clearing after reset.
module scanline_run_segment_extractor #(
  parameter int MAX_SEGMENTS = srse_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_WIDTH    = srse_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         glyph_width_we,
  input  logic [srse_pkg::GLYPH_W-1:0] glyph_width_data,
  srse_pix_if.sink                     pixels,
  srse_seg_if.source                   segments
);
  import srse_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 8);
  localparam int GW = (CW > GLYPH_W) ? CW : GLYPH_W;
  localparam int RW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state;
  logic [GLYPH_W-1:0] glyph_width;
  logic [CW-1:0]      column;
  logic               inside_run;
  logic [RW-1:0]      run_count;
  logic               overflowed;
  logic [CW-1:0]      open_start;
  logic [BYTE_W-1:0]  byte_q;
  logic [3:0]         bit_idx;
  logic [AW-1:0]      seg_idx;

  logic [GW-1:0]      w_ext;
  logic [CW-1:0]      w_now;
  logic [CW-1:0]      px;
  logic               scan_done;
  logic               row_more;
  logic               cur_set;
  logic               slot_free;
  logic [AW-1:0]      rc_addr;
  logic [RW-1:0]      rc_m1;
  logic [CW-1:0]      close_end;
  logic [AW-1:0]      rd_idx;
  logic               last_seg;
  logic               out_free;

  seg_wr_t            wr;
  logic [SEG_W-1:0]   wr_data;
  logic [SEG_W-1:0]   rd_start;
  logic [SEG_W-1:0]   rd_end;

  assign w_ext     = (GW'(glyph_width) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(glyph_width);
  assign w_now     = w_ext[CW-1:0];
  assign px        = column + CW'(bit_idx);
  assign scan_done = (bit_idx == 4'd8) || (px >= w_now);
  assign row_more  = ({1'b0, column} + (CW+1)'(8)) < {1'b0, w_now};
  assign cur_set   = byte_q[bit_idx[2:0]];
  assign slot_free = run_count < RW'(MAX_SEGMENTS);
  assign rc_addr   = run_count[AW-1:0];
  assign rc_m1     = run_count - RW'(1);
  assign close_end = (w_now > open_start) ? w_now : open_start;
  assign rd_idx    = (RW'(seg_idx) < run_count) ? seg_idx : rc_m1[AW-1:0];
  assign last_seg  = seg_idx == AW'(MAX_SEGMENTS - 1);
  assign out_free  = !segments.valid || segments.ready;

  assign pixels.ready = (state == ST_IDLE);

  always_comb begin
    wr      = '0;
    wr_data = SEG_W'(px);
    if (state == ST_SCAN) begin
      if (scan_done) begin
        wr.end_we = !row_more && inside_run;
        wr_data   = SEG_W'(close_end);
      end else if (cur_set && !inside_run) begin
        wr.start_we = slot_free;
      end else if (!cur_set && inside_run) begin
        wr.end_we = 1'b1;
      end
    end
  end

  srse_seg_store #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (rc_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_idx),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width <= GLYPH_WIDTH_RESET;
    end else if (glyph_width_we) begin
      glyph_width <= glyph_width_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      column     <= '0;
      inside_run <= 1'b0;
      run_count  <= '0;
      overflowed <= 1'b0;
      bit_idx    <= '0;
      seg_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pixels.valid) begin
            byte_q  <= pixels.pixel_byte;
            bit_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (row_more) begin
              column <= column + CW'(8);
              state  <= ST_IDLE;
            end else begin
              if (inside_run) begin
                run_count  <= run_count + RW'(1);
                inside_run <= 1'b0;
              end
              seg_idx <= '0;
              state   <= ST_RD;
            end
          end else begin
            bit_idx <= bit_idx + 4'd1;
            if (cur_set && !inside_run) begin
              if (slot_free) begin
                inside_run <= 1'b1;
                open_start <= px;
              end else begin
                overflowed <= 1'b1;
              end
            end else if (!cur_set && inside_run) begin
              run_count  <= run_count + RW'(1);
              inside_run <= 1'b0;
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            if (last_seg) begin
              column     <= '0;
              inside_run <= 1'b0;
              run_count  <= '0;
              overflowed <= 1'b0;
              state      <= ST_IDLE;
            end else begin
              seg_idx <= seg_idx + AW'(1);
              state   <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      segments.valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      segments.valid <= 1'b1;
    end else if (segments.ready) begin
      segments.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      if (run_count == '0) begin
        segments.seg_start <= SEG_W'(w_now >> 1);
        segments.seg_end   <= SEG_W'(w_now >> 1);
      end else begin
        segments.seg_start <= rd_start;
        segments.seg_end   <= rd_end;
      end
      segments.seg_final    <= last_seg;
      segments.run_overflow <= overflowed;
    end
  end

endmodule

@@ design/srse_checker.sv @@
// Port-level checks for the scanline run segment extractor, bound to the top level.
// Depends on srse_pkg and scanline_run_segment_extractor.
module srse_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pix_valid,
  input logic                       pix_ready,
  input logic                       seg_valid,
  input logic                       seg_ready,
  input logic [srse_pkg::SEG_W-1:0] seg_start,
  input logic [srse_pkg::SEG_W-1:0] seg_end,
  input logic                       seg_final
);
  import srse_pkg::*;

  // Out of reset: idle and nothing pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (pix_ready && !seg_valid))
    else $error("block not idle after reset");

  // A row's readout is not interrupted by a new pixel transaction.
  a_readout_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_ready && !seg_final) |-> !pix_ready)
    else $error("pixel channel open in the middle of a row readout");

  // Pixels are not taken while the previous byte is still being scanned.
  a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |=> !pix_ready)
    else $error("pixel transaction taken during a scan");

  // Stalled segment holds.
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !seg_ready) |=>
      (seg_valid && $stable(seg_start) && $stable(seg_end) && $stable(seg_final)))
    else $error("stalled segment changed");

endmodule

bind scanline_run_segment_extractor srse_checker u_srse_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixels.valid),
  .pix_ready (pixels.ready),
  .seg_valid (segments.valid),
  .seg_ready (segments.ready),
  .seg_start (segments.seg_start),
  .seg_end   (segments.seg_end),
  .seg_final (segments.seg_final)
);

@@ bench/scanline_run_segment_extractor_tb.sv @@
// Self-checking bench for scanline_run_segment_extractor: random pixel rows,
// glyph width changes (including mid-row), predicted segments compared per row.
// Depends on srse_pkg, srse_pix_if, srse_seg_if and the extractor RTL.
module scanline_run_segment_extractor_tb;
  import srse_pkg::*;

  localparam int NSEG        = DEF_MAX_SEGMENTS;
  localparam int WMAX        = DEF_MAX_WIDTH;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 24;
  localparam int RAND_BYTES  = 100;

  typedef struct {
    logic [SEG_W-1:0] seg_start;
    logic [SEG_W-1:0] seg_end;
    logic             seg_final;
    logic             run_overflow;
  } segment_t;

  class row_segment_book;
    int unsigned width_reg;
    int unsigned column;
    bit          in_run;
    int unsigned runs;
    int unsigned run_start[NSEG];
    int unsigned run_end[NSEG];
    bit          overflow;
    segment_t    expected_segs[$];
    int          errors;
    int          bytes_seen;
    int          rows_seen;
    int          segs_checked;

    function new();
      width_reg = GLYPH_WIDTH_RESET;
      errors = 0;
      bytes_seen = 0;
      rows_seen = 0;
      segs_checked = 0;
      clear_row();
    endfunction

    function void clear_row();
      column = 0;
      in_run = 0;
      runs = 0;
      overflow = 0;
    endfunction

    function void set_width(logic [GLYPH_W-1:0] w);
      width_reg = w;
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction

    function void note_pixel_byte(logic [BYTE_W-1:0] pix);
      int unsigned w;
      int unsigned px;
      int unsigned s;
      int unsigned e;
      int unsigned idx;
      segment_t seg;
      w = (width_reg > WMAX) ? WMAX : width_reg;
      bytes_seen++;
      for (int i = 0; i < BYTE_W; i++) begin
        px = column + i;
        if (px >= w) break;
        if (pix[i] && !in_run) begin
          if (runs < NSEG) begin
            run_start[runs] = px;
            in_run = 1;
          end else begin
            overflow = 1;
          end
        end else if (!pix[i] && in_run) begin
          if (runs < NSEG) run_end[runs] = px;
          runs++;
          in_run = 0;
        end
      end
      if (column + BYTE_W < w) begin
        column += BYTE_W;
        return;
      end
      // row end: close an open run at the width (never below its start)
      if (in_run && runs < NSEG) begin
        run_end[runs] = (w > run_start[runs]) ? w : run_start[runs];
        runs++;
        in_run = 0;
      end
      for (int k = 0; k < NSEG; k++) begin
        if (runs == 0) begin
          s = w / 2;
          e = w / 2;
        end else begin
          idx = (k < runs) ? k : runs - 1;
          if (idx >= NSEG) idx = NSEG - 1;
          s = run_start[idx];
          e = run_end[idx];
        end
        seg.seg_start    = s[SEG_W-1:0];
        seg.seg_end      = e[SEG_W-1:0];
        seg.seg_final    = (k == NSEG - 1);
        seg.run_overflow = overflow;
        expected_segs.push_back(seg);
      end
      rows_seen++;
      clear_row();
    endfunction

    function void check_segment(segment_t got);
      segment_t exp_seg;
      if (expected_segs.size() == 0) begin
        $error("segment with nothing expected: start %0d end %0d final %0b ovf %0b",
               got.seg_start, got.seg_end, got.seg_final, got.run_overflow);
        errors++;
        return;
      end
      exp_seg = expected_segs.pop_front();
      segs_checked++;
      if (got.seg_start !== exp_seg.seg_start) begin
        $error("seg_start: expected %0d, got %0d", exp_seg.seg_start, got.seg_start);
        errors++;
      end
      if (got.seg_end !== exp_seg.seg_end) begin
        $error("seg_end: expected %0d, got %0d", exp_seg.seg_end, got.seg_end);
        errors++;
      end
      if (got.seg_final !== exp_seg.seg_final) begin
        $error("seg_final: expected %0b, got %0b", exp_seg.seg_final, got.seg_final);
        errors++;
      end
      if (got.run_overflow !== exp_seg.run_overflow) begin
        $error("run_overflow: expected %0b, got %0b",
               exp_seg.run_overflow, got.run_overflow);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               glyph_width_we;
  logic [GLYPH_W-1:0] glyph_width_data;
  bit                 calm;
  bit                 hold_output;
  int                 rand_bytes;
  int unsigned        min_width;
  int unsigned        max_width;

  row_segment_book book;

  srse_pix_if pix_ch ();
  srse_seg_if seg_ch ();

  scanline_run_segment_extractor u_top (
    .clk              (clk),
    .rst              (rst),
    .glyph_width_we   (glyph_width_we),
    .glyph_width_data (glyph_width_data),
    .pixels           (pix_ch),
    .segments         (seg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01 << $urandom_range(0, 7);
      3: return ~(8'h01 << $urandom_range(0, 7));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [BYTE_W-1:0] pix);
    int gap;
    gap = idle_len();
    @(negedge clk);
    pix_ch.valid      <= 1'b1;
    pix_ch.pixel_byte <= pix;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    book.note_pixel_byte(pix);
    if (gap > 0) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(int unsigned w);
    wait_drained();
    @(negedge clk);
    glyph_width_we   <= 1'b1;
    glyph_width_data <= w[GLYPH_W-1:0];
    @(posedge clk);
    book.set_width(w[GLYPH_W-1:0]);
    if (w < min_width) min_width = w;
    if (w > max_width) max_width = w;
    @(negedge clk);
    glyph_width_we <= 1'b0;
  endtask

  task automatic send_rows(int rows, int unsigned w);
    int unsigned eff;
    int nbytes;
    eff = (w > WMAX) ? WMAX : w;
    nbytes = (eff == 0) ? 1 : (eff + 7) / 8;
    repeat (rows) begin
      repeat (nbytes) begin
        send_byte(pick_byte());
        rand_bytes++;
      end
    end
  endtask

  // output side: random stalls, one long hold on request
  initial begin : segment_sink
    int stall;
    segment_t got;
    stall = 0;
    seg_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        seg_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      if (stall > 0) begin
        seg_ch.ready <= 1'b0;
        stall--;
      end else begin
        seg_ch.ready <= 1'b1;
        stall = idle_len();
      end
      @(posedge clk);
      if (seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1) begin
        got.seg_start    = seg_ch.seg_start;
        got.seg_end      = seg_ch.seg_end;
        got.seg_final    = seg_ch.seg_final;
        got.run_overflow = seg_ch.run_overflow;
        book.check_segment(got);
      end
    end
  end

  initial begin : stimulus
    int unsigned w;
    int phase;
    book = new();
    rst = 1'b1;
    glyph_width_we = 1'b0;
    glyph_width_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_byte = '0;
    calm = 1'b0;
    hold_output = 1'b0;
    rand_bytes = 0;
    min_width = GLYPH_WIDTH_RESET;
    max_width = GLYPH_WIDTH_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: blank, full, edge runs, tiny widths, exact fill and overflow
    write_width(8);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h81);
    write_width(1);
    send_byte(8'hFE);
    send_byte(8'h01);
    write_width(0);
    send_byte(8'hFF);
    write_width(3);
    send_byte(8'hFF);
    write_width(40);
    repeat (5) send_byte(8'h55);
    write_width(42);
    repeat (6) send_byte(8'hAA);
    // width drops mid-row with an open run: closed at the width, then at its start
    write_width(16);
    send_byte(8'h80);
    write_width(8);
    send_byte(8'h3C);
    write_width(16);
    send_byte(8'h80);
    write_width(4);
    send_byte(8'hFF);

    // random rows: widest and saturated width once, then mostly narrow rows
    phase = 0;
    while (rand_bytes < RAND_BYTES) begin
      if (phase == 0) w = WMAX;
      else if (phase == 1) w = (1 << GLYPH_W) - 1;
      else if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 300);
      else w = $urandom_range(1, 64);
      write_width(w);
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_output = 1'b1;
      send_rows((w > 64) ? 1 : $urandom_range(1, 3), w);
      calm = 1'b0;
      phase++;
    end

    wait_drained();
    $display("Covered %0d pixel bytes in %0d rows, %0d segments compared;",
             book.bytes_seen, book.rows_seen, book.segs_checked);
    $display("glyph widths %0d..%0d, mid-row width drops, run overflow, output hold.",
             min_width, max_width);
    if (book.errors == 0) begin
      $display("scanline_run_segment_extractor_tb passed");
    end else begin
      $display("scanline_run_segment_extractor_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("scanline_run_segment_extractor_tb failed");
    $finish;
  end

endmodule
